// ----- rtl/core/request_id_tag_table_core_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef REQUEST_ID_TAG_TABLE_CORE_MACROS_SVH
`define REQUEST_ID_TAG_TABLE_CORE_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define RIDTT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ridtt assertion failed");

// Next-cycle implication, gated off during reset.
`define RIDTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ridtt assertion failed");

`endif

// ----- rtl/core/ridtt_pkg.sv -----
package ridtt_pkg;

   localparam int TABLE_SLOTS_DEF = 256;
   localparam int SEQ_W           = 8;

   typedef enum logic [1:0] {
      STAT_NEW      = 2'd0,
      STAT_FOUND    = 2'd1,
      STAT_REFUSED  = 2'd2,
      STAT_RELEASED = 2'd3
   } status_type;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DECIDE,
      FSM_SEEK,
      FSM_RESP
   } fsm_type;

   typedef struct packed {
      logic [31:0]      ident;
      logic [SEQ_W-1:0] seq;
      logic [15:0]      kind;
      logic [15:0]      flags;
      logic [31:0]      handle;
   } slot_type;

   typedef struct packed {
      logic match;
      logic empty;
   } probe_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] tag;
      logic [31:0] ident;
      logic [15:0] kind;
      logic [15:0] flags;
      logic [31:0] handle;
   } result_type;

endpackage

// ----- rtl/core/request_id_tag_table_core.sv -----
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_stall | op, ident, kind, flags, handle, tag_in
// rsp     | out | rsp_valid / rsp_stall | status, tag, ident, kind, flags, handle
//
// Flow: allocate scans every slot as the ring carries it past the head cell,
// then, to take an empty slot, waits for that slot to come round to the head
// cell; release waits for the tagged slot. A zero identifier or an out-of-range
// release answers without touching the ring. The ring moves one slot a cycle.
// Reset: synchronous; clears every slot and the control state.
// Stalls: one word in flight; req_stall stays high until the result word is
// loaded into the output register; rsp_stall holds that register.
module request_id_tag_table_core import ridtt_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_request_ident,
   input  logic [15:0] req_request_kind,
   input  logic [15:0] req_request_flags,
   input  logic [31:0] req_data_handle,
   input  logic [15:0] req_tag_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_tag_out,
   output logic [31:0] rsp_ident_out,
   output logic [15:0] rsp_kind_out,
   output logic [15:0] rsp_flags_out,
   output logic [31:0] rsp_handle_out
);

   localparam int          IW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

   // Ring of cells: cell 0 is the head, data moves toward it every cycle.
   slot_type  cell_out [TABLE_SLOTS];
   probe_type cell_probe [TABLE_SLOTS];
   slot_type  head_in;

   fsm_type       state_ff, state_in;
   logic [IW-1:0] rot_ff, rot_in;       // slot index sitting in the head cell
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] match_idx_ff, match_idx_in;
   logic [IW-1:0] empty_idx_ff, empty_idx_in;
   logic [SEQ_W-1:0] match_seq_ff, match_seq_in;
   logic          have_match_ff, have_match_in;
   logic          have_empty_ff, have_empty_in;
   logic [IW-1:0] target_ff, target_in;
   slot_type      req_ff, req_in;       // word held while working on it
   logic          op_ff, op_in;
   result_type    res_ff, res_in;
   result_type    rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          accept;
   logic          out_of_range;

   for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cell
      slot_type nxt;
      if (k == TABLE_SLOTS - 1) begin : g_tail
         assign nxt = head_in;
      end else begin : g_body
         assign nxt = cell_out[k+1];
      end
      ridtt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .slot_in  (nxt),
         .key      (req_ff.ident),
         .slot_out (cell_out[k]),
         .probe    (cell_probe[k])
      );
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = (state_ff != FSM_IDLE);
   assign accept       = req_valid && !req_stall;
   assign out_of_range = ({1'b0, req_tag_in[7:0]} >= 9'(TABLE_SLOTS));
   assign rot_in       = (rot_ff == LAST) ? '0 : rot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      match_idx_ff  <= match_idx_in;
      empty_idx_ff  <= empty_idx_in;
      match_seq_ff  <= match_seq_in;
      have_match_ff <= have_match_in;
      have_empty_ff <= have_empty_in;
      target_ff     <= target_in;
      req_ff        <= req_in;
      op_ff         <= op_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      match_idx_in  = match_idx_ff;
      empty_idx_in  = empty_idx_ff;
      match_seq_in  = match_seq_ff;
      have_match_in = have_match_ff;
      have_empty_in = have_empty_ff;
      target_in     = target_ff;
      req_in        = req_ff;
      op_in         = op_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      head_in       = cell_out[0];

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               req_in.ident  = req_request_ident;
               req_in.seq    = '0;
               req_in.kind   = req_request_kind;
               req_in.flags  = req_request_flags;
               req_in.handle = req_data_handle;
               op_in         = req_op;
               target_in     = IW'(req_tag_in[7:0]);
               res_in        = '0;
               cnt_in        = '0;
               have_match_in = 1'b0;
               have_empty_in = 1'b0;
               if (req_op == OP_RELEASE) begin
                  res_in.status = STAT_RELEASED;
                  state_in      = out_of_range ? FSM_RESP : FSM_SEEK;
               end else if (req_request_ident == 32'd0) begin
                  // zero marks empty slots; refuse it
                  res_in.status = STAT_REFUSED;
                  state_in      = FSM_RESP;
               end else begin
                  state_in = FSM_SCAN;
               end
            end
         end
         FSM_SCAN: begin
            // keep the lowest matching and the lowest empty slot
            if (cell_probe[0].match && (!have_match_ff || rot_ff < match_idx_ff)) begin
               have_match_in = 1'b1;
               match_idx_in  = rot_ff;
               match_seq_in  = cell_out[0].seq;
            end
            if (cell_probe[0].empty && (!have_empty_ff || rot_ff < empty_idx_ff)) begin
               have_empty_in = 1'b1;
               empty_idx_in  = rot_ff;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               state_in = FSM_DECIDE;
            end
         end
         FSM_DECIDE: begin
            if (have_match_ff) begin
               res_in.status = STAT_FOUND;
               res_in.tag    = {match_seq_ff, 8'(match_idx_ff)};
               state_in      = FSM_RESP;
            end else if (have_empty_ff) begin
               target_in = empty_idx_ff;
               state_in  = FSM_SEEK;
            end else begin
               res_in.status = STAT_REFUSED;
               state_in      = FSM_RESP;
            end
         end
         FSM_SEEK: begin
            if (rot_ff == target_ff) begin
               if (op_ff == OP_ALLOC) begin
                  head_in       = req_ff;
                  head_in.seq   = cell_out[0].seq + 1'b1;
                  res_in.status = STAT_NEW;
                  res_in.tag    = {cell_out[0].seq + 1'b1, 8'(rot_ff)};
               end else begin
                  head_in       = '0;
                  res_in.ident  = cell_out[0].ident;
                  res_in.kind   = cell_out[0].kind;
                  res_in.flags  = cell_out[0].flags;
                  res_in.handle = cell_out[0].handle;
               end
               state_in = FSM_RESP;
            end
         end
         FSM_RESP: begin
            // advance the word into the output register once it is free
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_tag_out    = rsp_ff.tag;
   assign rsp_ident_out  = rsp_ff.ident;
   assign rsp_kind_out   = rsp_ff.kind;
   assign rsp_flags_out  = rsp_ff.flags;
   assign rsp_handle_out = rsp_ff.handle;

endmodule

// ----- rtl/core/ridtt_cell.sv -----
// One slot of the rotating table; probes its contents against the search key.
module ridtt_cell import ridtt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  slot_type    slot_in,
   input  logic [31:0] key,
   output slot_type    slot_out,
   output probe_type   probe
);

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_out    = slot_ff;
   assign probe.match = (slot_ff.ident == key);
   assign probe.empty = (slot_ff.ident == 32'd0);

endmodule

// ----- rtl/core/ridtt_checker.sv -----
`include "request_id_tag_table_core_macros.svh"

module ridtt_checker import ridtt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_op,
   input logic [31:0] req_request_ident,
   input logic [15:0] req_request_kind,
   input logic [15:0] req_request_flags,
   input logic [31:0] req_data_handle,
   input logic [15:0] req_tag_in,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_tag_out,
   input logic [31:0] rsp_ident_out,
   input logic [15:0] rsp_kind_out,
   input logic [15:0] rsp_flags_out,
   input logic [31:0] rsp_handle_out
);

   // hold a stalled result word
   `RIDTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // refused words carry no tag
   `RIDTT_ASSERT_NOW(a_refused_tag, clock, reset, rsp_valid && rsp_status == STAT_REFUSED, rsp_tag_out == 16'd0)
   // release words carry no tag
   `RIDTT_ASSERT_NOW(a_release_tag, clock, reset, rsp_valid && rsp_status == STAT_RELEASED, rsp_tag_out == 16'd0)
   // a freshly taken slot was empty, so its sequence is one
   `RIDTT_ASSERT_NOW(a_new_seq, clock, reset, rsp_valid && rsp_status == STAT_NEW, rsp_tag_out[15:8] == 8'd1)

endmodule

bind request_id_tag_table_core ridtt_checker u_ridtt_checker (.*);

// ----- tb/tb_request_id_tag_table_checker.sv -----
`timescale 1ns / 1ps

module tb_request_id_tag_table_checker import ridtt_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_request_ident,
   input  logic [15:0] req_request_kind,
   input  logic [15:0] req_request_flags,
   input  logic [31:0] req_data_handle,
   input  logic [15:0] req_tag_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_tag_out,
   input  logic [31:0] rsp_ident_out,
   input  logic [15:0] rsp_kind_out,
   input  logic [15:0] rsp_flags_out,
   input  logic [31:0] rsp_handle_out,
   output int          fail_count,
   output int          pending_words
);

   slot_type   shadow_slots [TABLE_SLOTS];
   result_type tag_answers [$];

   assign pending_words = tag_answers.size();

   // Model one request word against the shadow table.
   function automatic result_type lookup_tag(op_type op, logic [31:0] ident,
         logic [15:0] kind, logic [15:0] flags, logic [31:0] handle,
         logic [15:0] tag);
      result_type r;
      int hit;
      int idx;
      r = '0;
      hit = -1;
      if (op == OP_RELEASE) begin
         r.status = STAT_RELEASED;
         idx = tag[7:0];
         if (idx < TABLE_SLOTS) begin
            r.ident  = shadow_slots[idx].ident;
            r.kind   = shadow_slots[idx].kind;
            r.flags  = shadow_slots[idx].flags;
            r.handle = shadow_slots[idx].handle;
            shadow_slots[idx] = '0;
         end
         return r;
      end
      if (ident == 0) begin
         r.status = STAT_REFUSED;
         return r;
      end
      for (int i = 0; i < TABLE_SLOTS; i++)
         if (hit < 0 && shadow_slots[i].ident == ident) hit = i;
      if (hit >= 0) begin
         r.status = STAT_FOUND;
         r.tag = {shadow_slots[hit].seq, 8'(hit)};
         return r;
      end
      for (int i = 0; i < TABLE_SLOTS; i++)
         if (hit < 0 && shadow_slots[i].ident == 0) hit = i;
      if (hit < 0) begin
         r.status = STAT_REFUSED;
         return r;
      end
      shadow_slots[hit].ident  = ident;
      shadow_slots[hit].seq    = shadow_slots[hit].seq + 8'd1;
      shadow_slots[hit].kind   = kind;
      shadow_slots[hit].flags  = flags;
      shadow_slots[hit].handle = handle;
      r.status = STAT_NEW;
      r.tag = {shadow_slots[hit].seq, 8'(hit)};
      return r;
   endfunction

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         foreach (shadow_slots[i]) shadow_slots[i] = '0;
         tag_answers.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            tag_answers.push_back(lookup_tag(op_type'(req_op), req_request_ident,
               req_request_kind, req_request_flags, req_data_handle, req_tag_in));
         if (rsp_valid && !rsp_stall) begin
            if (tag_answers.size() == 0) begin
               $error("unexpected result word");
               fail_count <= fail_count + 1;
            end else begin
               e = tag_answers.pop_front();
               if (rsp_status !== e.status || rsp_tag_out !== e.tag ||
                   rsp_ident_out !== e.ident || rsp_kind_out !== e.kind ||
                   rsp_flags_out !== e.flags || rsp_handle_out !== e.handle)
                  fail_count <= fail_count + 1;
               if (rsp_status !== e.status)
                  $error("status exp %0d got %0d", e.status, rsp_status);
               if (rsp_tag_out !== e.tag)
                  $error("tag_out exp %h got %h", e.tag, rsp_tag_out);
               if (rsp_ident_out !== e.ident)
                  $error("ident_out exp %h got %h", e.ident, rsp_ident_out);
               if (rsp_kind_out !== e.kind)
                  $error("kind_out exp %h got %h", e.kind, rsp_kind_out);
               if (rsp_flags_out !== e.flags)
                  $error("flags_out exp %h got %h", e.flags, rsp_flags_out);
               if (rsp_handle_out !== e.handle)
                  $error("handle_out exp %h got %h", e.handle, rsp_handle_out);
            end
         end
      end
   end

endmodule

// ----- tb/tb_request_id_tag_table_core.sv -----
`timescale 1ns / 1ps

module tb_request_id_tag_table_core;
   import ridtt_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [31:0] req_request_ident;
   logic [15:0] req_request_kind;
   logic [15:0] req_request_flags;
   logic [31:0] req_data_handle;
   logic [15:0] req_tag_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_tag_out;
   logic [31:0] rsp_ident_out;
   logic [15:0] rsp_kind_out;
   logic [15:0] rsp_flags_out;
   logic [31:0] rsp_handle_out;
   int          fail_count;
   int          pending_words;

   // Random idling runs until this goes high; the tail runs at full rate.
   logic        calm_tail;
   // Force one long receiver hold-off while the sender keeps pushing.
   logic        hold_drain;

   // Identifiers handed out so far, reused to hit the found path.
   logic [31:0] live_idents [$];
   // Random slot numbers, one per allocate, used for in-range releases.
   logic [15:0] live_tags [$];

   request_id_tag_table_core dut (.*);

   tb_request_id_tag_table_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold the receiver off for a long stretch once, and stall in random bursts until the calm tail.
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_drain) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(negedge clock);
            rsp_stall <= 1'b0;
            while (hold_drain) @(negedge clock);
         end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            @(negedge clock);
         end
      end
   end

   // Offer one word and hold it until accepted; valid stays up until the
   // next word or an idle gap replaces it.
   task automatic push_word(op_type op, logic [31:0] ident, logic [15:0] kind,
         logic [15:0] flags, logic [31:0] handle, logic [15:0] tag);
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_request_ident <= ident;
      req_request_kind  <= kind;
      req_request_flags <= flags;
      req_data_handle   <= handle;
      req_tag_in        <= tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic alloc_word(logic [31:0] ident);
      push_word(OP_ALLOC, ident, 16'($urandom), 16'($urandom), $urandom, 16'($urandom));
   endtask

   task automatic release_word(logic [15:0] tag);
      push_word(OP_RELEASE, $urandom, 16'($urandom), 16'($urandom), $urandom, tag);
   endtask

   // Draw an identifier, mostly from a narrow pool, so found hits are common.
   function automatic logic [31:0] pick_ident();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($urandom_range(1, 40));
         default: return live_idents.size() ? live_idents[$urandom_range(0,
            live_idents.size() - 1)] : $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] id;
      logic [15:0] t;
      int wait_cycles;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_op            = OP_ALLOC;
      req_request_ident = '0;
      req_request_kind  = '0;
      req_request_flags = '0;
      req_data_handle   = '0;
      req_tag_in        = '0;
      calm_tail         = 1'b0;
      hold_drain        = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, zero ident, found, release paths.
      push_word(OP_ALLOC, 32'hffff_ffff, 16'hffff, 16'hffff, 32'hffff_ffff, 16'hffff);
      push_word(OP_ALLOC, 32'h0000_0001, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000);
      push_word(OP_ALLOC, 32'h0000_0000, 16'h1234, 16'h5678, 32'h9abc_def0, 16'h0);
      push_word(OP_ALLOC, 32'hffff_ffff, 16'h0, 16'h0, 32'h0, 16'h0);
      push_word(OP_RELEASE, 32'h0, 16'h0, 16'h0, 32'h0, 16'hff00);
      push_word(OP_RELEASE, 32'hffff_ffff, 16'hffff, 16'hffff, 32'hffff_ffff, 16'h0001);
      push_word(OP_RELEASE, 32'h0, 16'h0, 16'h0, 32'h0, 16'h00ff);
      push_word(OP_RELEASE, 32'h0, 16'h0, 16'h0, 32'h0, 16'h0001);
      // Allocate and release a few times around the low slots.
      for (int i = 0; i < 4; i++) begin
         push_word(OP_ALLOC, 32'h0000_0002, 16'(i), 16'(~i), 32'(i), 16'h0);
         push_word(OP_RELEASE, 32'h0, 16'h0, 16'h0, 32'h0, 16'h0001);
      end
      push_word(OP_RELEASE, 32'h0, 16'h0, 16'h0, 32'h0, 16'h0000);

      // Fill the table, probe refusal when full, then free the upper half.
      for (int i = 0; i < 256; i++) alloc_word(32'h8000_0000 + i);
      alloc_word(32'h7fff_0001);
      alloc_word(32'h8000_00ff);
      for (int i = 255; i >= 128; i--)
         release_word(16'(($urandom_range(0, 255) << 8) | i));

      // Long receiver hold-off with the sender still pushing.
      hold_drain = 1'b1;
      for (int i = 0; i < 6; i++) alloc_word(32'($urandom_range(1, 100)));
      hold_drain = 1'b0;

      // Random mix: mostly allocates and in-range releases, some noise.
      for (int n = 0; n < 150; n++) begin
         if (n == 120) calm_tail = 1'b1;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               id = pick_ident();
               alloc_word(id);
               live_idents.push_back(id);
               live_tags.push_back(16'($urandom_range(0, 255)));
               if (live_idents.size() > 64) void'(live_idents.pop_front());
            end
            5, 6, 7: begin
               t = live_tags.size() ? live_tags.pop_front() : 16'($urandom);
               release_word(t);
            end
            8: alloc_word(32'h0);
            default: push_word(op_type'($urandom_range(0, 1)), $urandom,
               16'($urandom), 16'($urandom), $urandom, 16'($urandom));
         endcase
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_words != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (600) @(posedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Worst case is roughly 560 words, each with a full scan and seek of the ring,
   // plus the long hold-off and the drain wait, under 4 ms.
   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ridtt_pkg.sv
rtl/core/ridtt_cell.sv
rtl/core/request_id_tag_table_core.sv
rtl/core/ridtt_checker.sv
tb/tb_request_id_tag_table_checker.sv
tb/tb_request_id_tag_table_core.sv
